>>> src/bple_pkg.sv
`timescale 1ns / 1ps

package bple_pkg;

  // List geometry.
  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 6;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned HELD_W   = 6;
  localparam int unsigned CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Request kinds. Code 7 is unused and ignored.
  typedef enum logic [2:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_INS_POS   = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_BACK  = 3'd4,
    KIND_DEL_POS   = 3'd5,
    KIND_READ      = 3'd6
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // What every cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_e;

  // Control broadcast to the whole chain.
  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] tail_idx;
    logic [VAL_W-1:0] value;
  } chain_ctrl_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] item_value;
    logic [HELD_W-1:0]       entries_held;
    logic                    last;
  } out_t;

endpackage

>>> src/bple_cell.sv
`timescale 1ns / 1ps

module bple_cell import bple_pkg::*; (
  input  logic             clk_i,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  chain_ctrl_t      ctrl_i,
  input  logic [VAL_W-1:0] left_i,
  input  logic [VAL_W-1:0] right_i,
  input  logic [VAL_W-1:0] wrap_i,
  output logic [VAL_W-1:0] data_o
);

  logic [VAL_W-1:0] data_q;
  logic [VAL_W-1:0] data_d;

  // Pick the next value from this cell, a neighbor or the request.
  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      OP_HOLD: begin
        data_d = data_q;
      end
      OP_INSERT: begin
        if (cell_idx_i == ctrl_i.idx) begin
          data_d = ctrl_i.value;
        end else if (cell_idx_i > ctrl_i.idx) begin
          data_d = left_i;
        end
      end
      OP_DELETE: begin
        if (cell_idx_i >= ctrl_i.idx) begin
          data_d = right_i;
        end
      end
      OP_ROTATE: begin
        if (cell_idx_i == ctrl_i.tail_idx) begin
          data_d = wrap_i;
        end else begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> src/bple_chain.sv
`timescale 1ns / 1ps

module bple_chain import bple_pkg::*; (
  input  logic             clk_i,
  input  chain_ctrl_t      ctrl_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [VAL_W-1:0] rd_data_o,
  output logic [VAL_W-1:0] head_o
);

  logic [VAL_W-1:0] cell_data [CAPACITY];

  // Row of cells; inner cells see both neighbors; all see cell 0 for wrap.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_w;
    logic [VAL_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = ctrl_i.value;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    bple_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .ctrl_i     (ctrl_i),
      .left_i     (left_w),
      .right_i    (right_w),
      .wrap_i     (cell_data[0]),
      .data_o     (cell_data[g])
    );
  end

  // Value removed by a delete, and the front entry for read-out.
  assign rd_data_o = cell_data[rd_idx_i];
  assign head_o    = cell_data[0];

endmodule

>>> src/bounded_positional_list_engine_unit.sv
`timescale 1ns / 1ps

// Ordered list of signed 32-bit values, up to CAPACITY entries.
// Requests arrive on in_valid_i / in_stall_o / in_data_i and results leave on
// out_valid_o / out_stall_i / out_data_o. A transfer happens on a rising edge
// with valid high and stall low.
// Inserts and deletes act on the whole cell row at once; they and refused
// requests give one result in the cycle after the transfer. A new request is
// taken every cycle while no read-out runs and the output register is free or
// being emptied. A read-out of N entries gives N results front to back, one per
// cycle while the receiver does not stall; the row rotates by one cell per entry
// sent so the front cell always holds the entry going out. No request is taken
// until the last entry is in the output register. A read request on a non-empty
// list gives no result of its own.
// When the receiver stalls, the result holds in the output register and the
// input stalls once a further result would have no place to go.
// Reset empties the list; entry contents are not cleared and need no sweep.
// Kind code 7 is dropped without a result.
module bounded_positional_list_engine_unit import bple_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             reading_q, reading_d;
  logic [CNT_W-1:0] rd_left_q, rd_left_d;
  logic             out_valid_q;
  out_t             out_q;

  logic             slot_free;
  logic             in_fire;
  logic             emit;
  out_t             res;
  chain_ctrl_t      ctrl;
  logic [IDX_W-1:0] rd_idx;
  logic [VAL_W-1:0] rd_data;
  logic [VAL_W-1:0] head_data;
  logic             full;
  logic             empty;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_m1;
  logic [CNT_W-1:0] cnt_m1;
  logic             ins_pos_ok;
  logic             del_pos_ok;

  // Handshake.
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = reading_q || !slot_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Range checks against the current count.
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign pos_ext    = CMP_W'(in_data_i.position);
  assign cnt_ext    = CMP_W'(count_q);
  assign pos_m1     = pos_ext - CMP_W'(1);
  assign cnt_m1     = count_q - CNT_W'(1);
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
  assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);

  // Request decode: chain control, next count and the result.
  always_comb begin
    ctrl          = '0;
    ctrl.op       = OP_HOLD;
    ctrl.value    = in_data_i.value;
    ctrl.tail_idx = cnt_m1[IDX_W-1:0];
    rd_idx        = '0;
    count_d       = count_q;
    reading_d     = reading_q;
    rd_left_d     = rd_left_q;
    emit          = 1'b0;
    res           = '0;
    res.last      = 1'b1;

    if (reading_q) begin
      // Read-out in progress: send the front entry and rotate.
      if (slot_free) begin
        ctrl.op        = OP_ROTATE;
        emit           = 1'b1;
        res.status     = ST_OK;
        res.item_value = head_data;
        res.last       = (rd_left_q == CNT_W'(1));
        rd_left_d      = rd_left_q - CNT_W'(1);
        reading_d      = (rd_left_q != CNT_W'(1));
      end
    end else if (in_fire) begin
      emit = 1'b1;
      unique case (in_data_i.kind)
        KIND_INS_FRONT, KIND_INS_BACK: begin
          if (full) begin
            res.status = ST_FULL;
          end else begin
            ctrl.op    = OP_INSERT;
            ctrl.idx   = (in_data_i.kind == KIND_INS_FRONT) ? '0 : count_q[IDX_W-1:0];
            count_d    = count_q + CNT_W'(1);
            res.status = ST_OK;
          end
        end
        KIND_INS_POS: begin
          if (!ins_pos_ok) begin
            res.status = ST_BADPOS;
          end else if (full) begin
            res.status = ST_FULL;
          end else begin
            ctrl.op    = OP_INSERT;
            ctrl.idx   = pos_m1[IDX_W-1:0];
            count_d    = count_q + CNT_W'(1);
            res.status = ST_OK;
          end
        end
        KIND_DEL_FRONT, KIND_DEL_BACK: begin
          if (empty) begin
            res.status = ST_EMPTY;
          end else begin
            rd_idx         = (in_data_i.kind == KIND_DEL_FRONT) ? '0 : cnt_m1[IDX_W-1:0];
            ctrl.op        = OP_DELETE;
            ctrl.idx       = rd_idx;
            count_d        = cnt_m1;
            res.status     = ST_OK;
            res.item_value = rd_data;
          end
        end
        KIND_DEL_POS: begin
          if (!del_pos_ok) begin
            res.status = ST_BADPOS;
          end else begin
            rd_idx         = pos_m1[IDX_W-1:0];
            ctrl.op        = OP_DELETE;
            ctrl.idx       = rd_idx;
            count_d        = cnt_m1;
            res.status     = ST_OK;
            res.item_value = rd_data;
          end
        end
        KIND_READ: begin
          if (empty) begin
            res.status = ST_EMPTY;
          end else begin
            emit      = 1'b0;
            reading_d = 1'b1;
            rd_left_d = count_q;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    res.entries_held = HELD_W'(count_d);
  end

  bple_chain u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .head_o    (head_data)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      reading_q   <= 1'b0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      reading_q <= reading_d;
      rd_left_q <= rd_left_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A read-out always has entries left to send, no more than the list holds.
  a_read_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reading_q |-> (rd_left_q != '0) && (rd_left_q <= count_q))
    else $error("read-out counter out of range");

  // Sending the final entry ends the read-out with a last flag.
  a_read_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reading_q && slot_free && (rd_left_q == CNT_W'(1))
      |=> !reading_q && out_valid_o && out_data_o.last)
    else $error("read-out did not end on its final entry");

  // An accepted insert gives a single result in the next cycle.
  a_insert_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && ((in_data_i.kind == KIND_INS_FRONT) || (in_data_i.kind == KIND_INS_BACK)
      || (in_data_i.kind == KIND_INS_POS))
      |=> out_valid_o && out_data_o.last && !reading_q)
    else $error("insert transfer gave no result");

endmodule
